@@ sv/disparity_to_point_reprojection_unit_defines.svh @@
// Assertion macros used by the reprojection unit RTL.
`ifndef DISPARITY_TO_POINT_REPROJECTION_UNIT_DEFINES_SVH
`define DISPARITY_TO_POINT_REPROJECTION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DPR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("reprojection assertion failed");
`define DPR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("reprojection assertion failed");
`else
`define DPR_ASSERT(lbl, clk, rst_n, prop)
`define DPR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/dpr_pkg.sv @@
// Constants and types of the disparity to point reprojection unit.
package dpr_pkg;
    localparam int COORD_BITS     = 12;
    localparam int DISP_FRAC_BITS = 4;
    localparam int DISP_W         = 16;
    localparam int CFG_W          = 32;
    localparam int Q_W            = 32;
    localparam int NUM_W          = 34;
    localparam int PROD_W         = CFG_W + DISP_W;
    localparam int W_W = ((PROD_W > CFG_W + DISP_FRAC_BITS) ? PROD_W
                                                          : CFG_W + DISP_FRAC_BITS) + 1;
    localparam int SH             = 16 + DISP_FRAC_BITS;
    localparam int AHI_W          = NUM_W + SH - Q_W;
    localparam int NLANE          = 3;
    localparam int NREG           = 5;
    localparam int ADDR_W         = $clog2(NREG) + 2;
    localparam int IDX_W          = ADDR_W - 2;
    localparam int RGB_W          = 24;
    localparam logic [CFG_W-1:0] OFS_RESET = 32'h0001_0000;
    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_CX  = 3'd0,
        REG_CY  = 3'd1,
        REG_FOC = 3'd2,
        REG_IB  = 3'd3,
        REG_OFS = 3'd4
    } t_reg;

    typedef struct packed {
        logic                     valid;
        logic signed [PROD_W-1:0] prod;
        logic signed [NUM_W-1:0]  nx;
        logic signed [NUM_W-1:0]  ny;
        logic signed [NUM_W-1:0]  nz;
        logic [RGB_W-1:0]         rgb;
    } t_s1;

    typedef struct packed {
        logic                    valid;
        logic signed [W_W-1:0]   w;
        logic signed [NUM_W-1:0] nx;
        logic signed [NUM_W-1:0] ny;
        logic signed [NUM_W-1:0] nz;
        logic [RGB_W-1:0]        rgb;
    } t_s2;

    typedef struct packed {
        logic [NUM_W-1:0] mag;
        logic             nneg;
        logic             nzero;
    } t_num;

    typedef struct packed {
        logic                   valid;
        logic [W_W-1:0]         dvs;
        logic                   dneg;
        logic                   dzero;
        t_num [NLANE-1:0]       num;
        logic [RGB_W-1:0]       rgb;
    } t_s3;

    typedef struct packed {
        logic [W_W-1:0] rem;
        logic [Q_W-1:0] ql;
        logic           ovf;
        logic           nneg;
        logic           nzero;
    } t_lane;

    typedef struct packed {
        logic              valid;
        logic [W_W-1:0]    dvs;
        logic              dneg;
        logic              dzero;
        t_lane [NLANE-1:0] lane;
        logic [RGB_W-1:0]  rgb;
    } t_div;
endpackage

@@ sv/disparity_to_point_reprojection_unit.sv @@
// Stereo reprojection of a pixel stream into signed Q16.16 3-D points.
//
// Pixels enter on the i_valid/o_ready channel, one beat per pixel with
// column, row, disparity and BGR colour. Points leave on o_valid/i_ready
// as x, y, z, RGB colour and a saturation flag. A pixel whose disparity is
// zero or negative is accepted and yields no point.
// The pipeline takes one pixel per cycle while the output is not stalled.
// After the edge that takes a pixel, three stages form w and the numerator
// magnitudes, one loads the divider, 32 stages run a restoring divider that
// resolves one quotient bit per stage for all three coordinates, and one
// saturates into the output register.
// When the receiver stalls with a point waiting, the whole pipeline holds
// and o_ready falls; nothing is lost or repeated.
// Reset is synchronous and clears all valid bits and loads the registers
// with their defaults (offset term 1.0, all others 0).
// The APB port writes the five calibration registers at byte addresses
// 0, 4, 8, 12 and 16; it must only be written while the pipeline is empty.
`include "disparity_to_point_reprojection_unit_defines.svh"
module disparity_to_point_reprojection_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [dpr_pkg::COORD_BITS-1:0]          i_column,
    input  logic [dpr_pkg::COORD_BITS-1:0]          i_row,
    input  logic signed [dpr_pkg::DISP_W-1:0]       i_disparity,
    input  logic [7:0]                              i_blue,
    input  logic [7:0]                              i_green,
    input  logic [7:0]                              i_red,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [dpr_pkg::Q_W-1:0]          o_point_x,
    output logic signed [dpr_pkg::Q_W-1:0]          o_point_y,
    output logic signed [dpr_pkg::Q_W-1:0]          o_point_z,
    output logic [7:0]                              o_out_red,
    output logic [7:0]                              o_out_green,
    output logic [7:0]                              o_out_blue,
    output logic                                    o_saturated,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [dpr_pkg::ADDR_W-1:0]              paddr,
    input  logic [dpr_pkg::CFG_W-1:0]               pwdata,
    output logic [dpr_pkg::CFG_W-1:0]               prdata,
    output logic                                    pready
);
    localparam int NW = dpr_pkg::NUM_W;
    localparam int WW = dpr_pkg::W_W;
    localparam int QW = dpr_pkg::Q_W;

    logic [dpr_pkg::CFG_W-1:0] r_cx, r_cy, r_foc, r_ib, r_ofs;
    dpr_pkg::t_reg             reg_idx;
    logic                      cfg_wr;

    logic                      en;
    dpr_pkg::t_s1              r_s1, n_s1;
    dpr_pkg::t_s2              r_s2, n_s2;
    dpr_pkg::t_s3              r_s3, n_s3;
    dpr_pkg::t_div             r_div [0:QW];
    dpr_pkg::t_div             n_div0;

    logic                      r_out_valid;
    logic [QW-1:0]             r_px, r_py, r_pz;
    logic [dpr_pkg::RGB_W-1:0] r_rgb;
    logic                      r_sat;
    logic [QW-1:0]             n_pv [dpr_pkg::NLANE];
    logic [dpr_pkg::NLANE-1:0] n_ps;

    function automatic dpr_pkg::t_lane div_step(input dpr_pkg::t_lane l,
                                                input logic [WW-1:0] d);
        dpr_pkg::t_lane r;
        logic [WW:0]    t;
        r = l;
        t = {l.rem, l.ql[QW-1]};
        if (t >= {1'b0, d}) begin
            r.rem = WW'(t - {1'b0, d});
            r.ql  = {l.ql[QW-2:0], 1'b1};
        end else begin
            r.rem = t[WW-1:0];
            r.ql  = {l.ql[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = dpr_pkg::t_reg'(paddr[dpr_pkg::ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_foc <= '0;
            r_ib  <= '0;
            r_ofs <= dpr_pkg::OFS_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                dpr_pkg::REG_CX:  r_cx  <= pwdata;
                dpr_pkg::REG_CY:  r_cy  <= pwdata;
                dpr_pkg::REG_FOC: r_foc <= pwdata;
                dpr_pkg::REG_IB:  r_ib  <= pwdata;
                dpr_pkg::REG_OFS: r_ofs <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dpr_pkg::REG_CX:  prdata = r_cx;
            dpr_pkg::REG_CY:  prdata = r_cy;
            dpr_pkg::REG_FOC: prdata = r_foc;
            dpr_pkg::REG_IB:  prdata = r_ib;
            dpr_pkg::REG_OFS: prdata = r_ofs;
            default:          prdata = '0;
        endcase
    end

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        n_s1.valid = i_valid && (i_disparity > 0);
        n_s1.prod  = dpr_pkg::PROD_W'($signed(r_ib)) * dpr_pkg::PROD_W'(i_disparity);
        n_s1.nx    = -(NW'($signed(r_cx)) + (NW'(i_column) << 16));
        n_s1.ny    = -(NW'($signed(r_cy)) + (NW'(i_row) << 16));
        n_s1.nz    = NW'($signed(r_foc));
        n_s1.rgb   = {i_red, i_green, i_blue};
    end

    always_comb begin
        n_s2.valid = r_s1.valid;
        n_s2.w     = WW'(r_s1.prod)
                   + (WW'($signed(r_ofs)) <<< dpr_pkg::DISP_FRAC_BITS);
        n_s2.nx    = r_s1.nx;
        n_s2.ny    = r_s1.ny;
        n_s2.nz    = r_s1.nz;
        n_s2.rgb   = r_s1.rgb;
    end

    always_comb begin
        logic signed [NW-1:0] nv [dpr_pkg::NLANE];
        nv[0] = r_s2.nx;
        nv[1] = r_s2.ny;
        nv[2] = r_s2.nz;
        n_s3.valid = r_s2.valid;
        n_s3.dneg  = r_s2.w[WW-1];
        n_s3.dzero = (r_s2.w == '0);
        n_s3.dvs   = r_s2.w[WW-1] ? WW'(-r_s2.w) : WW'(r_s2.w);
        n_s3.rgb   = r_s2.rgb;
        for (int k = 0; k < dpr_pkg::NLANE; k++) begin
            n_s3.num[k].nneg  = nv[k][NW-1];
            n_s3.num[k].nzero = (nv[k] == '0);
            n_s3.num[k].mag   = nv[k][NW-1] ? NW'(-nv[k]) : NW'(nv[k]);
        end
    end

    always_comb begin
        logic [NW+dpr_pkg::SH-1:0] a;
        logic [dpr_pkg::AHI_W-1:0] ahi;
        a   = '0;
        ahi = '0;
        n_div0.valid = r_s3.valid;
        n_div0.dvs   = r_s3.dvs;
        n_div0.dneg  = r_s3.dneg;
        n_div0.dzero = r_s3.dzero;
        n_div0.rgb   = r_s3.rgb;
        for (int k = 0; k < dpr_pkg::NLANE; k++) begin
            a   = {r_s3.num[k].mag, {dpr_pkg::SH{1'b0}}};
            ahi = a[NW+dpr_pkg::SH-1:QW];
            n_div0.lane[k].rem   = WW'(ahi);
            n_div0.lane[k].ql    = a[QW-1:0];
            n_div0.lane[k].ovf   = (WW'(ahi) >= r_s3.dvs);
            n_div0.lane[k].nneg  = r_s3.num[k].nneg;
            n_div0.lane[k].nzero = r_s3.num[k].nzero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid     <= 1'b0;
            r_s2.valid     <= 1'b0;
            r_s3.valid     <= 1'b0;
            r_div[0].valid <= 1'b0;
        end else if (en) begin
            r_s1     <= n_s1;
            r_s2     <= n_s2;
            r_s3     <= n_s3;
            r_div[0] <= n_div0;
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            dpr_pkg::t_div n_div;
            n_div = r_div[g];
            for (int k = 0; k < dpr_pkg::NLANE; k++) begin
                n_div.lane[k] = div_step(r_div[g].lane[k], r_div[g].dvs);
            end
            if (!i_rst_n) begin
                r_div[g+1].valid <= 1'b0;
            end else if (en) begin
                r_div[g+1] <= n_div;
            end
        end
    end

    always_comb begin
        dpr_pkg::t_lane l;
        logic           neg;
        l   = r_div[QW].lane[0];
        neg = 1'b0;
        for (int k = 0; k < dpr_pkg::NLANE; k++) begin
            l   = r_div[QW].lane[k];
            neg = l.nneg ^ r_div[QW].dneg;
            if (r_div[QW].dzero) begin
                n_ps[k] = 1'b1;
                n_pv[k] = l.nzero ? '0 : (l.nneg ? dpr_pkg::Q_MIN : dpr_pkg::Q_MAX);
            end else if (neg) begin
                if (l.ovf || (l.ql > dpr_pkg::Q_MIN)) begin
                    n_ps[k] = 1'b1;
                    n_pv[k] = dpr_pkg::Q_MIN;
                end else begin
                    n_ps[k] = 1'b0;
                    n_pv[k] = QW'(-l.ql);
                end
            end else begin
                if (l.ovf || l.ql[QW-1]) begin
                    n_ps[k] = 1'b1;
                    n_pv[k] = dpr_pkg::Q_MAX;
                end else begin
                    n_ps[k] = 1'b0;
                    n_pv[k] = l.ql;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_div[QW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px  <= n_pv[0];
            r_py  <= n_pv[1];
            r_pz  <= n_pv[2];
            r_sat <= |n_ps;
            r_rgb <= r_div[QW].rgb;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_point_x   = r_px;
    assign o_point_y   = r_py;
    assign o_point_z   = r_pz;
    assign o_out_red   = r_rgb[23:16];
    assign o_out_green = r_rgb[15:8];
    assign o_out_blue  = r_rgb[7:0];
    assign o_saturated = r_sat;

    `DPR_ASSERT(a_stall_backpressure, i_clk, i_rst_n, (o_valid && !i_ready) |-> !o_ready)
    `DPR_ASSERT(a_drop_nonpositive, i_clk, i_rst_n,
                (i_valid && o_ready && (i_disparity <= 0)) |=> !r_s1.valid)
    `DPR_ASSERT(a_zero_w_flags, i_clk, i_rst_n,
                (r_div[0].valid && r_div[0].dzero) |-> (r_div[0].lane[0].ovf
                && r_div[0].lane[1].ovf && r_div[0].lane[2].ovf))
    `DPR_ASSERT(a_zero_w_saturates, i_clk, i_rst_n,
                (en && r_div[QW].valid && r_div[QW].dzero) |=> (o_valid && o_saturated))
    `DPR_ASSERT(a_reset_clears_out, i_clk, i_rst_n, $rose(i_rst_n) |-> !o_valid)
endmodule

@@ bench/reprojection_checker.sv @@
// Checker that predicts each 3-D point from the pixel beats and compares it.
`timescale 1ns / 100ps
module reprojection_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               o_ready,
    input  logic [dpr_pkg::COORD_BITS-1:0]     i_column,
    input  logic [dpr_pkg::COORD_BITS-1:0]     i_row,
    input  logic signed [dpr_pkg::DISP_W-1:0]  i_disparity,
    input  logic [7:0]                         i_blue,
    input  logic [7:0]                         i_green,
    input  logic [7:0]                         i_red,
    input  logic                               o_valid,
    input  logic                               i_ready,
    input  logic signed [dpr_pkg::Q_W-1:0]     o_point_x,
    input  logic signed [dpr_pkg::Q_W-1:0]     o_point_y,
    input  logic signed [dpr_pkg::Q_W-1:0]     o_point_z,
    input  logic [7:0]                         o_out_red,
    input  logic [7:0]                         o_out_green,
    input  logic [7:0]                         o_out_blue,
    input  logic                               o_saturated,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dpr_pkg::ADDR_W-1:0]         paddr,
    input  logic [dpr_pkg::CFG_W-1:0]          pwdata,
    input  logic                               pready,
    output int                                 o_pending_points,
    output int                                 o_failures
);
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        sat;
    } t_point;

    t_point expected_points[$];
    logic signed [31:0] cx, cy, foc, ib, ofs;

    function automatic logic [31:0] sat_quotient(longint num, longint den, inout bit ovf);
        longint unsigned mag_n;
        longint unsigned mag_d;
        longint unsigned q;
        bit neg;
        if (den == 0) begin
            ovf = 1'b1;
            if (num > 0) return 32'h7FFF_FFFF;
            if (num < 0) return 32'h8000_0000;
            return 32'h0;
        end
        neg = (num < 0) != (den < 0);
        mag_n = (num < 0) ? longint'(-num) : longint'(num);
        mag_d = (den < 0) ? longint'(-den) : longint'(den);
        q = (mag_n << (16 + dpr_pkg::DISP_FRAC_BITS)) / mag_d;
        if (neg) begin
            if (q > 64'h8000_0000) begin
                ovf = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return 32'(q);
    endfunction

    function automatic t_point project_pixel(logic [dpr_pkg::COORD_BITS-1:0] col,
                                             logic [dpr_pkg::COORD_BITS-1:0] row,
                                             logic signed [dpr_pkg::DISP_W-1:0] disp,
                                             logic [7:0] b, logic [7:0] g,
                                             logic [7:0] r);
        t_point p;
        longint w;
        bit ovf;
        ovf = 1'b0;
        w = longint'(ib) * longint'(disp)
            + longint'(ofs) * (longint'(1) << dpr_pkg::DISP_FRAC_BITS);
        p.x = sat_quotient(-(longint'(cx) + longint'(col) * 65536), w, ovf);
        p.y = sat_quotient(-(longint'(cy) + longint'(row) * 65536), w, ovf);
        p.z = sat_quotient(longint'(foc), w, ovf);
        p.red = r;
        p.green = g;
        p.blue = b;
        p.sat = ovf;
        return p;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            o_failures++;
        end
    endtask

    initial o_failures = 0;

    always @(posedge i_clk) begin
        t_point e;
        if (!i_rst_n) begin
            cx <= '0;
            cy <= '0;
            foc <= '0;
            ib <= '0;
            ofs <= dpr_pkg::OFS_RESET;
            expected_points.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_points.size() == 0) begin
                    $error("point beat with no pixel pending");
                    o_failures++;
                end else begin
                    e = expected_points.pop_front();
                    compare_field("point_x", e.x, o_point_x);
                    compare_field("point_y", e.y, o_point_y);
                    compare_field("point_z", e.z, o_point_z);
                    compare_field("out_red", e.red, o_out_red);
                    compare_field("out_green", e.green, o_out_green);
                    compare_field("out_blue", e.blue, o_out_blue);
                    compare_field("saturated", e.sat, o_saturated);
                end
            end
            if (i_valid && o_ready && i_disparity > 0)
                expected_points = {expected_points,
                                   project_pixel(i_column, i_row, i_disparity,
                                                 i_blue, i_green, i_red)};
            if (psel && penable && pwrite && pready) begin
                case (paddr[dpr_pkg::ADDR_W-1:2])
                    dpr_pkg::REG_CX:  cx <= pwdata;
                    dpr_pkg::REG_CY:  cy <= pwdata;
                    dpr_pkg::REG_FOC: foc <= pwdata;
                    dpr_pkg::REG_IB:  ib <= pwdata;
                    dpr_pkg::REG_OFS: ofs <= pwdata;
                    default: ;
                endcase
            end
        end
        o_pending_points = expected_points.size();
    end
endmodule

@@ bench/tb.sv @@
// Top of the reprojection testbench: pixel stimulus, APB setup and verdict.
`timescale 1ns / 100ps
module tb;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [dpr_pkg::COORD_BITS-1:0] i_column = '0;
    logic [dpr_pkg::COORD_BITS-1:0] i_row = '0;
    logic signed [dpr_pkg::DISP_W-1:0] i_disparity = '0;
    logic [7:0] i_blue = '0, i_green = '0, i_red = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [dpr_pkg::Q_W-1:0] o_point_x, o_point_y, o_point_z;
    logic [7:0] o_out_red, o_out_green, o_out_blue;
    logic o_saturated;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [dpr_pkg::ADDR_W-1:0] paddr = '0;
    logic [dpr_pkg::CFG_W-1:0] pwdata = '0;
    logic [dpr_pkg::CFG_W-1:0] prdata;
    logic pready;
    int pending_points;
    int failures;
    int cycles = 0;
    bit calm = 1'b0;

    always #1 i_clk = ~i_clk;

    disparity_to_point_reprojection_unit DUT (.*);

    reprojection_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_column, .i_row, .i_disparity,
        .i_blue, .i_green, .i_red, .o_valid, .i_ready, .o_point_x, .o_point_y,
        .o_point_z, .o_out_red, .o_out_green, .o_out_blue, .o_saturated,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_pending_points(pending_points), .o_failures(failures)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 14);
    end

    task automatic write_reg(dpr_pkg::t_reg r, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_points();
        while (pending_points != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_calibration(logic [31:0] cxv, logic [31:0] cyv, logic [31:0] fv,
                                    logic [31:0] ibv, logic [31:0] ofv);
        drain_points();
        write_reg(dpr_pkg::REG_CX, cxv);
        write_reg(dpr_pkg::REG_CY, cyv);
        write_reg(dpr_pkg::REG_FOC, fv);
        write_reg(dpr_pkg::REG_IB, ibv);
        write_reg(dpr_pkg::REG_OFS, ofv);
    endtask

    task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [15:0] disp,
                              logic [7:0] b, logic [7:0] g, logic [7:0] r);
        i_valid <= 1'b1;
        i_column <= col;
        i_row <= row;
        i_disparity <= disp;
        i_blue <= b;
        i_green <= g;
        i_red <= r;
        do @(posedge i_clk); while (!o_ready);
        if (!calm && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic finish_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_pixel(bit plausible);
        logic [15:0] disp;
        if (plausible) disp = 16'($urandom_range(1, 4095));
        else disp = 16'($urandom);
        send_pixel(12'($urandom), 12'($urandom), disp,
                   8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic random_calibration(int kind);
        case (kind)
            0: load_calibration(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF);
            1: load_calibration(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000);
            2: load_calibration(-32'($urandom_range(0, 2048) << 16),
                                -32'($urandom_range(0, 2048) << 16),
                                32'($urandom_range(100, 2000) << 16),
                                32'($urandom_range(1, 65536)), 32'($urandom_range(0, 65536)));
            default: load_calibration($urandom, $urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel(12'd0, 12'd0, 16'sd16, 8'h00, 8'hFF, 8'h00);
        send_pixel(12'hFFF, 12'hFFF, 16'sh7FFF, 8'hFF, 8'h00, 8'hFF);
        send_pixel(12'd5, 12'd7, 16'sd0, 8'h11, 8'h22, 8'h33);
        send_pixel(12'd5, 12'd7, 16'sh8000, 8'h44, 8'h55, 8'h66);
        send_pixel(12'd5, 12'd7, 16'shFFFF, 8'h44, 8'h55, 8'h66);
        send_pixel(12'd9, 12'd3, 16'sd1, 8'hA5, 8'h5A, 8'hC3);
        finish_burst();

        load_calibration(-32'(640 << 16), -32'(360 << 16), 32'(700 << 16),
                         32'h0000_0800, 32'h0);
        send_pixel(12'd640, 12'd360, 16'sd1, 8'h01, 8'h02, 8'h03);
        send_pixel(12'd0, 12'd0, 16'sd1, 8'h01, 8'h02, 8'h03);
        send_pixel(12'hFFF, 12'hFFF, 16'sd1024, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(12'd100, 12'd200, 16'sh7FFF, 8'h10, 8'h20, 8'h30);
        finish_burst();

        load_calibration(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0);
        send_pixel(12'd0, 12'd0, 16'sd16, 8'h01, 8'h02, 8'h03);
        send_pixel(12'd3, 12'd1, 16'sd16, 8'h04, 8'h05, 8'h06);
        send_pixel(12'hFFF, 12'd0, 16'sd200, 8'h07, 8'h08, 8'h09);
        finish_burst();

        load_calibration(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1);
        send_pixel(12'hFFF, 12'hFFF, 16'sd1, 8'hFF, 8'h00, 8'h80);
        send_pixel(12'd0, 12'd0, 16'sh7FFF, 8'h00, 8'hFF, 8'h7F);
        finish_burst();

        for (int ph = 0; ph < 6; ph++) begin
            random_calibration(ph % 4);
            calm = (ph == 3);
            for (int n = 0; n < 140; n++) random_pixel($urandom_range(99) < 70);
            finish_burst();
        end
        calm = 1'b0;

        drain_points();
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/dpr_pkg.sv
sv/disparity_to_point_reprojection_unit.sv
bench/reprojection_checker.sv
bench/tb.sv
